// ===== hw/rtl/sacl_pkg.sv =====
// Shared types, codes and helpers of the set-associative LRU tag store.
package sacl_pkg;

    // Defaults of the top-level parameters
    localparam int SET_BITS_MAX_DEF = 6;
    localparam int WAYS_DEF         = 8;

    // Fixed field widths
    localparam int ADDR_W   = 64;
    localparam int STAMP_W  = 32;
    localparam int TOTAL_W  = 32;
    localparam int SHIFT_W  = 7;   // holds set bits + block bits
    localparam int CFG_W    = 6;   // widest configuration register
    localparam int CFG_IDX_W = 2;
    localparam int OUT_W    = 104; // 100 bits of fields, padded to bytes

    // Address split: set plus block bits at or above this give a zero tag
    localparam logic [SHIFT_W-1:0] TAG_SHIFT_LIMIT = SHIFT_W'(ADDR_W);

    // Command codes
    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_STORE  = 2'd1,
        CMD_MODIFY = 2'd2,
        CMD_IFETCH = 2'd3
    } cmd_t;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd2;

    // One way of a set as stored in the tag memory
    typedef struct packed {
        logic               valid;
        logic [ADDR_W-1:0]  tag;
        logic [STAMP_W-1:0] stamp;
    } way_t;

    // Lookup outcome of one set
    typedef struct packed {
        logic hit;   // a way in use holds the tag
        logic full;  // every way in use is valid
    } sel_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK
    } state_t;

    // Saturating increment of a running total
    function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v,
                                                   input logic en);
        sat_inc = (en && (v != '1)) ? v + TOTAL_W'(1) : v;
    endfunction

endpackage

// ===== hw/rtl/set_assoc_lru_cache_tags_unit.sv =====
// Top level of the set-associative LRU tag store: sequencer, counters, ports.
//
//  Channel  Dir  Handshake          Payload
//  s_       in   s_tvalid/s_tready  s_tdata address, s_tuser cmd
//  m_       out  m_tvalid/m_tready  m_tdata flags and running totals
//  cfg_     in   cfg_we             cfg_addr index, cfg_wdata value
//
// Each access reads the set row from the tag memory in ST_IDLE as the word is
// taken, then in ST_LOOK compares, picks the way and, but for an ifetch,
// writes the row back; the next word is taken in the cycle after. After reset
// a clearing pass writes all 2^SET_BITS_MAX rows, one per cycle, with s_tready
// low. A result waits in the output register; a new word is still taken, and
// its write-back waits only while the previous result is not taken.
module set_assoc_lru_cache_tags_unit #(
    parameter int SET_BITS_MAX = sacl_pkg::SET_BITS_MAX_DEF,
    parameter int WAYS         = sacl_pkg::WAYS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // access words
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [sacl_pkg::ADDR_W-1:0]        s_tdata,  // [63:0] address
    input  logic [1:0]                         s_tuser,  // [1:0] cmd
    // result words
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [1:0] hits_now, [2] missed, [3] evicted, [35:4] total_hits,
    // [67:36] total_misses, [99:68] total_evictions, [103:100] zero
    output logic [sacl_pkg::OUT_W-1:0]         m_tdata,
    // configuration writes
    input  logic                               cfg_we,
    input  logic [sacl_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [sacl_pkg::CFG_W-1:0]         cfg_wdata
);
    import sacl_pkg::*;

    localparam int ROW_W    = (SET_BITS_MAX > 0) ? SET_BITS_MAX : 1;
    localparam int NUM_SETS = 1 << SET_BITS_MAX;
    localparam int WN_W     = $clog2(WAYS + 1);
    localparam int IDX_W    = (WAYS > 1) ? $clog2(WAYS) : 1;

    // configuration registers
    logic [2:0] cfg_set_bits_reg;
    logic [3:0] cfg_ways_reg;
    logic [5:0] cfg_block_bits_reg;

    // sequencer and working registers
    state_t             state_reg, state_next;
    logic [ROW_W-1:0]   clr_idx_reg;
    cmd_t               cmd_reg;
    logic [ADDR_W-1:0]  tag_reg;
    logic [ROW_W-1:0]   set_reg;
    logic [WN_W-1:0]    ways_reg;

    // state counters
    logic [STAMP_W-1:0] stamp_reg;
    logic [TOTAL_W-1:0] hit_total_reg;
    logic [TOTAL_W-1:0] miss_total_reg;
    logic [TOTAL_W-1:0] evict_total_reg;

    // output register
    logic               m_tvalid_reg;
    logic [OUT_W-1:0]   m_tdata_reg;

    // address split and effective configuration
    logic [3:0]          set_bits_eff;
    logic [SHIFT_W-1:0]  tag_shift;
    logic [ADDR_W-1:0]   tag_in;
    logic [ADDR_W-1:0]   set_shifted;
    logic [ROW_W-1:0]    set_mask;
    logic [ROW_W-1:0]    set_in;
    logic [WN_W-1:0]     ways_in;

    // memory and lookup
    logic               ram_we;
    logic [ROW_W-1:0]   ram_waddr;
    way_t [WAYS-1:0]    ram_wdata;
    way_t [WAYS-1:0]    ram_rdata;
    logic               s_accept;
    sel_t               sel;
    logic [IDX_W-1:0]   target;
    logic               finish;
    logic               active;
    logic               hit_inc;
    logic               mod_inc;
    logic [1:0]         hits_now;
    logic               missed;
    logic               evicted;
    logic [TOTAL_W-1:0] hit_total_next;
    logic [TOTAL_W-1:0] miss_total_next;
    logic [TOTAL_W-1:0] evict_total_next;

    // configuration writes; indexes beyond the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_set_bits_reg   <= '0;
            cfg_ways_reg       <= 4'd1;
            cfg_block_bits_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_SET_BITS:   cfg_set_bits_reg   <= cfg_wdata[2:0];
                CFG_WAYS:       cfg_ways_reg       <= cfg_wdata[3:0];
                CFG_BLOCK_BITS: cfg_block_bits_reg <= cfg_wdata[5:0];
                default: ;
            endcase
        end
    end

    // set bits clamp, tag shift and set index
    always_comb begin
        set_bits_eff = ({1'b0, cfg_set_bits_reg} > 4'(SET_BITS_MAX)) ?
                       4'(SET_BITS_MAX) : {1'b0, cfg_set_bits_reg};
        tag_shift    = SHIFT_W'(set_bits_eff) + SHIFT_W'(cfg_block_bits_reg);
        tag_in       = (tag_shift >= TAG_SHIFT_LIMIT) ? '0 : (s_tdata >> tag_shift);
        set_shifted  = s_tdata >> cfg_block_bits_reg;
        set_mask     = ~({ROW_W{1'b1}} << set_bits_eff);
        set_in       = set_shifted[ROW_W-1:0] & set_mask;
    end

    // ways in use: zero counts as one, clamp to WAYS
    always_comb begin
        if (cfg_ways_reg == 4'd0) begin
            ways_in = WN_W'(1);
        end else if ({1'b0, cfg_ways_reg} > 5'(WAYS)) begin
            ways_in = WN_W'(WAYS);
        end else begin
            ways_in = WN_W'(cfg_ways_reg);
        end
    end

    sacl_row_ram #(
        .SET_BITS_MAX (SET_BITS_MAX),
        .WAYS         (WAYS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (s_accept),
        .raddr (set_in),
        .rdata (ram_rdata)
    );

    sacl_way_select #(
        .WAYS (WAYS)
    ) u_sel (
        .row    (ram_rdata),
        .tag    (tag_reg),
        .ways   (ways_reg),
        .sel    (sel),
        .target (target)
    );

    // sequencer: next state, handshake and memory write
    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        finish     = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = set_reg;
        ram_wdata  = ram_rdata;
        ram_wdata[target].valid = 1'b1;
        ram_wdata[target].tag   = tag_reg;
        ram_wdata[target].stamp = stamp_reg;
        case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_idx_reg;
                ram_wdata = '0;
                if (clr_idx_reg == ROW_W'(NUM_SETS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK: begin
                if (!m_tvalid_reg || m_tready) begin
                    finish     = 1'b1;
                    ram_we     = active;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_idx_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_idx_reg <= clr_idx_reg + ROW_W'(1);
            end
        end
    end

    // latch the access word
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cmd_reg  <= cmd_t'(s_tuser);
            tag_reg  <= tag_in;
            set_reg  <= set_in;
            ways_reg <= ways_in;
        end
    end

    // per-access flags and new totals
    always_comb begin
        active           = (cmd_reg != CMD_IFETCH);
        hit_inc          = active && sel.hit;
        mod_inc          = (cmd_reg == CMD_MODIFY);
        missed           = active && !sel.hit;
        evicted          = missed && sel.full;
        hits_now         = {1'b0, hit_inc} + {1'b0, mod_inc};
        hit_total_next   = sat_inc(sat_inc(hit_total_reg, hit_inc), mod_inc);
        miss_total_next  = sat_inc(miss_total_reg, missed);
        evict_total_next = sat_inc(evict_total_reg, evicted);
    end

    // counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stamp_reg       <= '0;
            hit_total_reg   <= '0;
            miss_total_reg  <= '0;
            evict_total_reg <= '0;
        end else if (finish) begin
            if (active) begin
                stamp_reg <= stamp_reg + STAMP_W'(1);
            end
            hit_total_reg   <= hit_total_next;
            miss_total_reg  <= miss_total_next;
            evict_total_reg <= evict_total_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (finish) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (finish) begin
            m_tdata_reg <= {4'd0, evict_total_next, miss_total_next, hit_total_next,
                            evicted, missed, hits_now};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== hw/rtl/sacl_row_ram.sv =====
// Tag memory: one row per set, all ways of the set in one word, registered read.
module sacl_row_ram #(
    parameter int SET_BITS_MAX = sacl_pkg::SET_BITS_MAX_DEF,
    parameter int WAYS         = sacl_pkg::WAYS_DEF,
    localparam int ROW_W       = (SET_BITS_MAX > 0) ? SET_BITS_MAX : 1
) (
    input  logic                          aclk,
    input  logic                          we,
    input  logic [ROW_W-1:0]              waddr,
    input  sacl_pkg::way_t [WAYS-1:0]     wdata,
    input  logic                          re,
    input  logic [ROW_W-1:0]              raddr,
    output sacl_pkg::way_t [WAYS-1:0]     rdata
);
    import sacl_pkg::*;

    localparam int NUM_SETS = 1 << SET_BITS_MAX;

    way_t [WAYS-1:0] mem [NUM_SETS];
    way_t [WAYS-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/sacl_way_select.sv =====
// Tag compare, free-way search and LRU victim choice over one set row.
module sacl_way_select #(
    parameter int WAYS   = sacl_pkg::WAYS_DEF,
    localparam int WN_W  = $clog2(WAYS + 1),
    localparam int IDX_W = (WAYS > 1) ? $clog2(WAYS) : 1
) (
    input  sacl_pkg::way_t [WAYS-1:0]       row,
    input  logic [sacl_pkg::ADDR_W-1:0]     tag,
    input  logic [WN_W-1:0]                 ways,
    output sacl_pkg::sel_t                  sel,
    output logic [IDX_W-1:0]                target
);
    import sacl_pkg::*;

    logic [WAYS-1:0]    in_use;
    logic [WAYS-1:0]    hit_vec;
    logic [WAYS-1:0]    free_vec;
    logic [IDX_W-1:0]   hit_idx;
    logic [IDX_W-1:0]   free_idx;
    logic [IDX_W-1:0]   lru_idx;
    logic [STAMP_W-1:0] low;
    logic               found;

    // per-way flags
    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            in_use[w]   = (w < int'(ways));
            hit_vec[w]  = in_use[w] && row[w].valid && (row[w].tag == tag);
            free_vec[w] = in_use[w] && !row[w].valid;
        end
    end

    // lowest hitting way and lowest free way
    always_comb begin
        hit_idx  = '0;
        free_idx = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (hit_vec[w]) begin
                hit_idx = IDX_W'(w);
            end
            if (free_vec[w]) begin
                free_idx = IDX_W'(w);
            end
        end
    end

    // oldest stamp among valid ways in use, lowest way wins a tie
    always_comb begin
        lru_idx = '0;
        low     = '0;
        found   = 1'b0;
        for (int w = 0; w < WAYS; w++) begin
            if (in_use[w] && row[w].valid && (!found || row[w].stamp < low)) begin
                low     = row[w].stamp;
                lru_idx = IDX_W'(w);
                found   = 1'b1;
            end
        end
    end

    assign sel.hit  = |hit_vec;
    assign sel.full = ~|free_vec;
    assign target   = sel.hit ? hit_idx : (sel.full ? lru_idx : free_idx);

endmodule
